// ----- design/rcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rcfp_pkg
// Types, constants and the CRC-8 step shared by the RC channel frame parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

	localparam int PAYLOAD_BYTES = 22;
	localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
	localparam int CHANNEL_BITS  = 11;
	localparam int BUFFER_BYTES  = 64;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] CRC_POLY       = 8'hD5;
	localparam logic [7:0] ADDR_FC        = 8'hC8;
	localparam logic [7:0] ADDR_RADIO_TX  = 8'hEA;
	localparam logic [7:0] ADDR_MODULE_TX = 8'hEE;
	localparam logic [7:0] TYPE_RC_PACKED = 8'h16;
	localparam logic [7:0] LEN_MIN        = 8'd2;
	localparam logic [7:0] LEN_MAX        = 8'd62;
	localparam logic [7:0] LEN_RC         = 8'd24;

	localparam logic [6:0] POS_HUNT   = 7'd0;
	localparam logic [6:0] POS_LENGTH = 7'd1;
	localparam logic [6:0] POS_TYPE   = 7'd2;
	localparam logic [6:0] POS_FIRST  = 7'd3;

	typedef logic [PAYLOAD_BITS-1:0] payload_t;

	typedef struct packed {
		logic     valid;
		payload_t payload;
	} frame_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- design/rcfp_front.sv -----
// ----------------------------------------------------------------------------
// rcfp_front
// Frame sync, length check, CRC and payload capture; pushes good frames.
// ----------------------------------------------------------------------------
module rcfp_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             rx_byte,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  rcfp_pkg::queue_status_t q_status,
	output rcfp_pkg::frame_push_t  push
);
	import rcfp_pkg::*;

	logic [6:0] pos_q;
	logic [7:0] len_q;
	logic       type_ok_q;
	logic [7:0] crc_q;
	logic [7:0] store_q [PAYLOAD_BYTES];

	logic       accept;
	logic       is_addr;
	logic       at_end;
	logic       frame_ok;
	logic [6:0] pos_inc;
	logic [6:0] store_off;
	logic [4:0] store_idx;

	assign in_stall  = q_status.full;
	assign accept    = in_valid && !in_stall;
	assign is_addr   = (rx_byte == ADDR_FC) || (rx_byte == ADDR_RADIO_TX)
		|| (rx_byte == ADDR_MODULE_TX);
	assign at_end    = ({2'b00, pos_q} == ({1'b0, len_q} + 9'd1));
	assign frame_ok  = type_ok_q && (len_q == LEN_RC) && (crc_q == rx_byte);
	assign pos_inc   = pos_q + 7'd1;
	assign store_off = pos_q - POS_FIRST;
	assign store_idx = store_off[4:0];

	always_comb begin
		push.valid = accept && (pos_q != POS_HUNT) && (pos_q != POS_LENGTH) && at_end
			&& frame_ok;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			push.payload[i*8 +: 8] = store_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_HUNT;
			len_q     <= '0;
			type_ok_q <= 1'b0;
			crc_q     <= '0;
		end else if (accept) begin
			if (pos_q == POS_HUNT) begin
				if (is_addr) begin
					pos_q <= POS_LENGTH;
				end
			end else if (pos_q == POS_LENGTH) begin
				if (rx_byte < LEN_MIN || rx_byte > LEN_MAX) begin
					pos_q <= POS_HUNT;
					len_q <= '0;
				end else begin
					pos_q <= POS_TYPE;
					len_q <= rx_byte;
				end
			end else if (at_end) begin
				pos_q     <= POS_HUNT;
				len_q     <= '0;
				type_ok_q <= 1'b0;
				crc_q     <= '0;
			end else begin
				crc_q <= crc8_step(crc_q, rx_byte);
				if (pos_q == POS_TYPE) begin
					type_ok_q <= (rx_byte == TYPE_RC_PACKED);
				end
				if ({25'd0, pos_inc} >= BUFFER_BYTES) begin
					pos_q     <= POS_HUNT;
					len_q     <= '0;
					type_ok_q <= 1'b0;
					crc_q     <= '0;
				end else begin
					pos_q <= pos_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (pos_q >= POS_FIRST) && !at_end
			&& ({25'd0, store_off} < PAYLOAD_BYTES)) begin
			store_q[store_idx] <= rx_byte;
		end
	end

endmodule

// ----- design/rcfp_queue.sv -----
// ----------------------------------------------------------------------------
// rcfp_queue
// Short queue of accepted frame payloads between the parser and the emitter.
// ----------------------------------------------------------------------------
module rcfp_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rcfp_pkg::frame_push_t   push,
	input  logic                    pop,
	output rcfp_pkg::queue_status_t status,
	output rcfp_pkg::payload_t      head
);
	import rcfp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

	payload_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];
	assign do_push      = push.valid && !status.full;
	assign do_pop       = pop && !status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.payload;
		end
	end

endmodule

// ----- design/rcfp_back.sv -----
// ----------------------------------------------------------------------------
// rcfp_back
// Takes one queued payload at a time and emits its channels, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module rcfp_back #(
	parameter int CHANNEL_COUNT = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rcfp_pkg::queue_status_t q_status,
	input  rcfp_pkg::payload_t      head,
	output logic                    pop,
	output logic [3:0]              channel_index,
	output logic [10:0]             channel_value,
	output logic                    last_channel,
	output logic                    out_valid,
	input  logic                    out_stall
);
	import rcfp_pkg::*;

	localparam logic [3:0] LAST_CH = 4'(CHANNEL_COUNT - 1);

	payload_t   frame_q;
	logic       busy_q;
	logic [3:0] ch_q;
	logic       emit;
	logic [7:0] bit_off;
	payload_t   shifted;

	assign pop     = !busy_q && !q_status.empty;
	assign emit    = busy_q && (!out_valid || !out_stall);
	assign bit_off = 8'(ch_q * CHANNEL_BITS);
	assign shifted = frame_q >> bit_off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			ch_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (emit) begin
				if (ch_q == LAST_CH) begin
					busy_q <= 1'b0;
				end
				ch_q <= ch_q + 4'd1;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= head;
		end
		if (emit) begin
			channel_index <= ch_q;
			channel_value <= shifted[CHANNEL_BITS-1:0];
			last_channel  <= (ch_q == LAST_CH);
		end
	end

endmodule

// ----- design/rc_channel_frame_parser_top.sv -----
// ----------------------------------------------------------------------------
// rc_channel_frame_parser_top
// Takes one link byte per cycle unless stalled. Good frames pass the queue,
// frame and output registers; the sixteen channels follow one per cycle unless
// out_stall holds, set by the single emitter. Input stalls only while two
// frames wait in the queue. Reset clears sync, queue and output state at once.
// ----------------------------------------------------------------------------
module rc_channel_frame_parser_top #(
	parameter int CHANNEL_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_value,
	output logic        last_channel,
	output logic        out_valid,
	input  logic        out_stall
);
	import rcfp_pkg::*;

	frame_push_t   push;
	queue_status_t q_status;
	payload_t      head;
	logic          pop;

	rcfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.q_status (q_status),
		.push     (push)
	);

	rcfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.status (q_status),
		.head   (head)
	);

	rcfp_back #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.head          (head),
		.pop           (pop),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last_channel  (last_channel),
		.out_valid     (out_valid),
		.out_stall     (out_stall)
	);

endmodule

// ----- test/rc_channel_frame_parser_top_tb.sv -----
// ----------------------------------------------------------------------------
// rc_channel_frame_parser_top_tb
// Feeds link bytes to the RC channel frame parser through its valid/stall
// request channel. A directed table of frames, bad lengths and noise comes
// first, followed by random frame sequences under several idling patterns on
// both sides. A byte-level predictor tracks sync, CRC and payload and queues
// the sixteen channels of every good frame. Each returned channel is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module rc_channel_frame_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcfp_pkg::*;

	localparam int CHANNELS     = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int DIRECTED_ROWS = 9;

	typedef enum logic [1:0] {ROW_NOISE, ROW_FRAME, ROW_BADLEN} row_kind_t;
	typedef enum logic [1:0] {PAT_ZERO, PAT_ONES, PAT_RAND} pattern_t;
	typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_ZEROS, OUT_ONES} outcome_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [7:0] lead;
		logic [7:0] len;
		logic [7:0] ftype;
		pattern_t   pat;
		logic       crc_good;
		outcome_t   outcome;
	} stim_row_t;

	typedef struct packed {
		logic [3:0]  index;
		logic [10:0] value;
		logic        last;
	} channel_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [3:0]  channel_index;
	logic [10:0] channel_value;
	logic        last_channel;
	logic        out_valid;
	logic        out_stall = 1'b0;

	logic [6:0] sync_pos;
	logic [7:0] frame_len;
	logic       type_ok;
	logic [7:0] run_crc;
	logic [7:0] payload_copy [PAYLOAD_BYTES];

	channel_result_t pending_channels [$];
	stim_row_t       directed_rows [DIRECTED_ROWS];
	outcome_t        byte_outcome = OUT_MODEL;

	int errors        = 0;
	int results_seen  = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int send_idle_tbl [4] = '{0, 60, 0, 28};
	int stall_tbl     [4] = '{0, 0, 60, 28};

	rc_channel_frame_parser_top #(
		.CHANNEL_COUNT(CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(rx_byte),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.last_channel(last_channel),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		r = crc ^ data;
		repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	function automatic void restart_hunt();
		sync_pos  = POS_HUNT;
		frame_len = 8'd0;
		type_ok   = 1'b0;
		run_crc   = 8'h00;
	endfunction

	// Returns one when the byte closes a good RC channel frame.
	function automatic logic parse_byte(input logic [7:0] b);
		logic good;
		good = 1'b0;
		if (sync_pos == POS_HUNT) begin
			if (b == ADDR_FC || b == ADDR_RADIO_TX || b == ADDR_MODULE_TX) begin
				restart_hunt();
				sync_pos = POS_LENGTH;
			end
		end else if (sync_pos == POS_LENGTH) begin
			if (b < LEN_MIN || b > LEN_MAX) begin
				restart_hunt();
			end else begin
				frame_len = b;
				sync_pos  = POS_TYPE;
			end
		end else if (int'(sync_pos) == int'(frame_len) + 1) begin
			good = type_ok && frame_len == LEN_RC && run_crc == b;
			restart_hunt();
		end else begin
			run_crc = crc8_next(run_crc, b);
			if (sync_pos == POS_TYPE) begin
				type_ok = (b == TYPE_RC_PACKED);
			end else if (int'(sync_pos) - int'(POS_FIRST) < PAYLOAD_BYTES) begin
				payload_copy[int'(sync_pos) - int'(POS_FIRST)] = b;
			end
			sync_pos = sync_pos + 7'd1;
			if (int'(sync_pos) >= BUFFER_BYTES) begin
				restart_hunt();
			end
		end
		return good;
	endfunction

	function automatic logic [10:0] channel_of(input int ch);
		logic [PAYLOAD_BITS-1:0] bits;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			bits[i*8 +: 8] = payload_copy[i];
		end
		return bits[ch*CHANNEL_BITS +: CHANNEL_BITS];
	endfunction

	function automatic void take_byte(input logic [7:0] b, input outcome_t outcome);
		logic            good;
		channel_result_t r;
		good = parse_byte(b);
		if (outcome == OUT_MODEL && !good) begin
			return;
		end
		if (outcome == OUT_NONE) begin
			return;
		end
		for (int ch = 0; ch < CHANNELS; ch++) begin
			r.index = ch[3:0];
			r.last  = (ch == CHANNELS - 1);
			case (outcome)
				OUT_ZEROS: r.value = 11'd0;
				OUT_ONES:  r.value = 11'h7FF;
				default:   r.value = channel_of(ch);
			endcase
			pending_channels.push_back(r);
		end
	endfunction

	function automatic void check_result();
		channel_result_t want;
		results_seen++;
		if (pending_channels.size() == 0) begin
			$error("unexpected channel: index %0d value %0d last %0b",
				channel_index, channel_value, last_channel);
			errors++;
			return;
		end
		want = pending_channels.pop_front();
		if (channel_index !== want.index) begin
			$error("channel_index: expected %0d, got %0d", want.index, channel_index);
			errors++;
		end
		if (channel_value !== want.value) begin
			$error("channel_value: expected %0d, got %0d", want.value, channel_value);
			errors++;
		end
		if (last_channel !== want.last) begin
			$error("last_channel: expected %0b, got %0b", want.last, last_channel);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				take_byte(rx_byte, byte_outcome);
			end
			if (out_valid && !out_stall) begin
				check_result();
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Called just after a falling edge; returns just after a falling edge.
	task automatic send_byte(input logic [7:0] b, input outcome_t outcome);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		byte_outcome = outcome;
		rx_byte  <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] addr, input logic [7:0] len,
			input logic [7:0] ftype, input pattern_t pat, input logic crc_good,
			input outcome_t outcome);
		logic [7:0] crc;
		logic [7:0] b;
		send_byte(addr, OUT_MODEL);
		send_byte(len, OUT_MODEL);
		crc = crc8_next(8'h00, ftype);
		send_byte(ftype, OUT_MODEL);
		for (int n = 0; n < int'(len) - 2; n++) begin
			case (pat)
				PAT_ZERO: b = 8'h00;
				PAT_ONES: b = 8'hFF;
				default:  b = 8'($urandom_range(255));
			endcase
			crc = crc8_next(crc, b);
			send_byte(b, OUT_MODEL);
		end
		send_byte(crc_good ? crc : crc ^ (8'h01 << $urandom_range(7)), outcome);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_channels.size() != 0) @(negedge clk);
	endtask

	initial begin
		int         seq;
		int         result_base;
		int         pick;
		logic [7:0] addr;
		logic [7:0] len;
		logic [7:0] ftype;

		restart_hunt();
		directed_rows = '{
			'{ROW_NOISE,  8'h00,          8'd0,   8'h00,          PAT_ZERO, 1'b1, OUT_NONE},
			'{ROW_NOISE,  TYPE_RC_PACKED, 8'd0,   8'h00,          PAT_ZERO, 1'b1, OUT_NONE},
			'{ROW_FRAME,  ADDR_FC,        LEN_RC, TYPE_RC_PACKED, PAT_ZERO, 1'b1, OUT_ZEROS},
			'{ROW_FRAME,  ADDR_RADIO_TX,  LEN_RC, TYPE_RC_PACKED, PAT_ONES, 1'b1, OUT_ONES},
			'{ROW_FRAME,  ADDR_MODULE_TX, LEN_MIN, TYPE_RC_PACKED, PAT_RAND, 1'b1, OUT_NONE},
			'{ROW_BADLEN, ADDR_FC,        8'd0,   8'h00,          PAT_ZERO, 1'b1, OUT_NONE},
			'{ROW_BADLEN, ADDR_RADIO_TX,  LEN_MIN - 8'd1, 8'h00,  PAT_ZERO, 1'b1, OUT_NONE},
			'{ROW_BADLEN, ADDR_MODULE_TX, LEN_MAX + 8'd1, 8'h00,  PAT_ZERO, 1'b1, OUT_NONE},
			'{ROW_BADLEN, ADDR_FC,        ADDR_MODULE_TX, 8'h00,  PAT_ZERO, 1'b1, OUT_NONE}
		};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_NOISE: begin
					send_byte(directed_rows[i].lead, directed_rows[i].outcome);
				end
				ROW_BADLEN: begin
					send_byte(directed_rows[i].lead, OUT_MODEL);
					send_byte(directed_rows[i].len, directed_rows[i].outcome);
				end
				default: begin
					send_frame(directed_rows[i].lead, directed_rows[i].len,
						directed_rows[i].ftype, directed_rows[i].pat,
						directed_rows[i].crc_good, directed_rows[i].outcome);
				end
			endcase
		end
		hold_until_drained();

		result_base = results_seen;
		seq = 0;
		while (seq < 4 || results_seen - result_base < 16) begin
			send_idle_pct = send_idle_tbl[seq % 4];
			stall_pct     = stall_tbl[seq % 4];
			if ($urandom_range(7) == 0) begin
				hold_until_drained();
			end
			case ($urandom_range(2))
				0:       addr = ADDR_FC;
				1:       addr = ADDR_RADIO_TX;
				default: addr = ADDR_MODULE_TX;
			endcase
			pick = $urandom_range(99);
			if (pick < 58) begin
				send_frame(addr, LEN_RC, TYPE_RC_PACKED, PAT_RAND, 1'b1, OUT_MODEL);
			end else if (pick < 68) begin
				send_frame(addr, LEN_RC, TYPE_RC_PACKED, PAT_RAND, 1'b0, OUT_MODEL);
			end else if (pick < 73) begin
				ftype = 8'($urandom_range(255));
				send_frame(addr, LEN_RC, ftype, PAT_RAND, 1'b1, OUT_MODEL);
			end else if (pick < 83) begin
				len   = 8'($urandom_range(LEN_MAX, LEN_MIN));
				ftype = $urandom_range(1) ? TYPE_RC_PACKED : 8'($urandom_range(255));
				send_frame(addr, len, ftype, PAT_RAND, 1'b1, OUT_MODEL);
			end else if (pick < 88) begin
				len = $urandom_range(1) ? 8'($urandom_range(LEN_MIN - 1))
					: 8'($urandom_range(255, LEN_MAX + 1));
				send_byte(addr, OUT_MODEL);
				send_byte(len, OUT_MODEL);
			end else if (pick < 95) begin
				repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)), OUT_MODEL);
			end else begin
				send_byte(addr, OUT_MODEL);
				send_byte(LEN_RC, OUT_MODEL);
				send_byte(TYPE_RC_PACKED, OUT_MODEL);
				repeat ($urandom_range(20)) send_byte(8'($urandom_range(255)), OUT_MODEL);
			end
			seq++;
		end

		in_valid <= 1'b0;
		while (pending_channels.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
